FILE: rtl/dvs_speed_governor_core_macros.svh
// Assertion macros shared by the speed governor RTL.
`ifndef DVS_SPEED_GOVERNOR_CORE_MACROS_SVH
`define DVS_SPEED_GOVERNOR_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSG_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/dsg_pkg.sv
// Package: widths, reset values, register codes and control structs of the speed governor.
`default_nettype none
package dsg_pkg;

	localparam int COUNTER_WIDTH_DEF = 32;

	localparam int TICK_W     = 10;
	localparam int SPEED_W    = 7;
	localparam int WEIGHT_W   = 8;
	localparam int AVG_W      = 17; // run/deadline ticks times speed fits here
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 10;

	localparam logic [SPEED_W-1:0] FULL_SPEED = 7'd100;

	localparam logic [TICK_W-1:0]   RST_INTERVAL  = 10'd50;
	localparam logic [SPEED_W-1:0]  RST_MIN_SPEED = 7'd5;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = 8'd20;
	localparam logic [SPEED_W-1:0]  RST_HIGH_TH   = 7'd70;
	localparam logic [SPEED_W-1:0]  RST_LOW_TH    = 7'd50;
	localparam logic [SPEED_W-1:0]  RST_UP_STEP   = 7'd20;
	localparam logic [SPEED_W-1:0]  RST_DOWN_BASE = 7'd60;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERVAL,
		REG_MIN_SPEED,
		REG_AVG_WEIGHT,
		REG_HIGH_TH,
		REG_LOW_TH,
		REG_UP_STEP,
		REG_DOWN_BASE
	} reg_idx_t;

	// Division jobs run in this order when an interval closes
	typedef enum logic [2:0] {
		OP_AVG_WORK,
		OP_AVG_DEAD,
		OP_PMAX,
		OP_UTIL,
		OP_USED
	} op_t;

	typedef struct packed {
		logic accept;
		logic load;
		logic store;
		logic emit;
		logic close;
		op_t  op;
	} dp_cmd_t;

	typedef struct packed {
		logic close;
		logic div_done;
		logic out_busy;
	} dp_status_t;

endpackage
`default_nettype wire

FILE: rtl/dsg_tick_if.sv
// Tick channel: one word per scheduler tick.
`default_nettype none
interface dsg_tick_if;
	logic       valid;
	logic       ready;
	logic       is_idle;
	logic [6:0] current_speed;

	modport source (output valid, output is_idle, output current_speed, input ready);
	modport sink   (input valid, input is_idle, input current_speed, output ready);
endinterface
`default_nettype wire

FILE: rtl/dsg_result_if.sv
// Result channel: one word per tick.
`default_nettype none
interface dsg_result_if;
	logic       valid;
	logic       ready;
	logic       interval_end;
	logic       change_request;
	logic [6:0] new_speed;
	logic [6:0] predicted_max;

	modport source (output valid, output interval_end, output change_request,
		output new_speed, output predicted_max, input ready);
	modport sink   (input valid, input interval_end, input change_request,
		input new_speed, input predicted_max, output ready);
endinterface
`default_nettype wire

FILE: rtl/dsg_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module dsg_div #(
	parameter int NW = 39,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo,
	output logic [DW-1:0] rem
);
	localparam int CNT_W = $clog2(NW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    rem_q;
	logic [DW-1:0]    den_q;
	logic [DW:0]      rem_sh;
	logic [DW:0]      diff;
	logic             ge;

	// trial subtract of the shifted partial remainder
	always_comb begin
		rem_sh = {rem_q, quo_q[NW-1]};
		diff   = rem_sh - {1'b0, den_q};
		ge     = (rem_sh >= {1'b0, den_q});
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// quotient shifts in from the bottom as the dividend leaves the top
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			quo_q <= {quo_q[NW-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
	assign rem  = rem_q;
endmodule
`default_nettype wire

FILE: rtl/dsg_datapath.sv
// Datapath: settings, tick counters, averages, divider and result register.
`default_nettype none
module dsg_datapath #(
	parameter int CW = dsg_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dsg_pkg::dp_cmd_t                  cmd,
	output dsg_pkg::dp_status_t               status,
	input  logic                              tick_is_idle,
	input  logic [dsg_pkg::SPEED_W-1:0]       tick_current_speed,
	input  logic                              cfg_we,
	input  logic [dsg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dsg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	dsg_result_if.source                      result
);
	import dsg_pkg::*;

	localparam int NUM_MIN = AVG_W + WEIGHT_W + 1;
	localparam int NW = (CW + SPEED_W > NUM_MIN) ? CW + SPEED_W : NUM_MIN;
	localparam int DW = (CW > AVG_W) ? CW : AVG_W;

	// divide-by-100 unit: one dividend byte per cycle
	localparam int UW   = ((NW + 7) / 8) * 8;
	localparam int NCH  = UW / 8;
	localparam int CH_W = $clog2(NCH + 1);
	// floor(v / 100) == (v * RECIP_100) >> 23 for every v below 2^15
	localparam logic [16:0] RECIP_100 = 17'd83887;

	// settings
	logic [TICK_W-1:0]   intv_q;
	logic [SPEED_W-1:0]  minsp_q;
	logic [WEIGHT_W-1:0] wgt_q;
	logic [SPEED_W-1:0]  hith_q;
	logic [SPEED_W-1:0]  loth_q;
	logic [SPEED_W-1:0]  up_q;
	logic [SPEED_W-1:0]  dnb_q;

	// governor state
	logic [TICK_W-1:0]  tick_q;
	logic [TICK_W-1:0]  run_q;
	logic [TICK_W-1:0]  idle_q;
	logic [SPEED_W-1:0] speed_q;
	logic [CW-1:0]      excess_q;
	logic [CW-1:0]      rt_q;
	logic [CW-1:0]      t_q;
	logic [CW-1:0]      xnew_q;
	logic [AVG_W-1:0]   aw_q;
	logic [AVG_W-1:0]   ad_q;
	logic [SPEED_W-1:0] maxl_q;
	logic [SPEED_W-1:0] pct_q;

	// result register
	logic               res_valid_q;
	logic               res_end_q;
	logic               res_cr_q;
	logic [SPEED_W-1:0] res_ns_q;
	logic [SPEED_W-1:0] res_pmax_q;

	// divider hookup
	logic [NW-1:0] div_num;
	logic [DW-1:0] div_den;
	logic [NW-1:0] div_quo;
	logic [DW-1:0] div_rem;
	logic          div_done;
	logic          div_start;

	// divide-by-100 state
	logic [UW-1:0]   c100_x_q;
	logic [6:0]      c100_r_q;
	logic [CH_W-1:0] c100_cnt_q;
	logic            c100_busy_q;
	logic            c100_done_q;
	logic            c100_start;
	logic [14:0]     c100_v;
	logic [31:0]     c100_prod;
	logic [7:0]      c100_digit;
	logic [14:0]     c100_back;
	logic [14:0]     c100_rem;

	logic [AVG_W+WEIGHT_W-1:0] aw_mul;
	logic [AVG_W+WEIGHT_W-1:0] ad_mul;
	logic [AVG_W-1:0]          nw;
	logic [AVG_W-1:0]          nd;
	logic [CW:0]               s1;
	logic [CW:0]               s2;
	logic [CW-1:0]             rt_c;
	logic [CW-1:0]             t_c;
	logic [WEIGHT_W:0]         wgt_p1;

	logic signed [9:0]  s_sp;
	logic signed [9:0]  s_rule;
	logic signed [9:0]  s_lim;
	logic signed [9:0]  s_fin;
	logic [SPEED_W-1:0] ns_close;
	logic [SPEED_W-1:0] ns_out;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			intv_q  <= RST_INTERVAL;
			minsp_q <= RST_MIN_SPEED;
			wgt_q   <= RST_WEIGHT;
			hith_q  <= RST_HIGH_TH;
			loth_q  <= RST_LOW_TH;
			up_q    <= RST_UP_STEP;
			dnb_q   <= RST_DOWN_BASE;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_INTERVAL:   intv_q  <= cfg_wdata[TICK_W-1:0];
				REG_MIN_SPEED:  minsp_q <= cfg_wdata[SPEED_W-1:0];
				REG_AVG_WEIGHT: wgt_q   <= cfg_wdata[WEIGHT_W-1:0];
				REG_HIGH_TH:    hith_q  <= cfg_wdata[SPEED_W-1:0];
				REG_LOW_TH:     loth_q  <= cfg_wdata[SPEED_W-1:0];
				REG_UP_STEP:    up_q    <= cfg_wdata[SPEED_W-1:0];
				REG_DOWN_BASE:  dnb_q   <= cfg_wdata[SPEED_W-1:0];
				default: ;
			endcase
		end
	end

	// operand forming: products and saturated sums
	always_comb begin
		aw_mul = {{WEIGHT_W{1'b0}}, aw_q} * {{AVG_W{1'b0}}, wgt_q};
		ad_mul = {{WEIGHT_W{1'b0}}, ad_q} * {{AVG_W{1'b0}}, wgt_q};
		nw     = AVG_W'(run_q) * AVG_W'(speed_q);
		nd     = (AVG_W'(run_q) + AVG_W'(idle_q)) * AVG_W'(speed_q);
		wgt_p1 = {1'b0, wgt_q} + 1'b1;
		s1     = {1'b0, excess_q} + (CW+1)'(run_q);
		rt_c   = s1[CW] ? '1 : s1[CW-1:0];
		s2     = {1'b0, rt_c} + (CW+1)'(idle_q);
		t_c    = s2[CW] ? '1 : s2[CW-1:0];
	end

	// dividend and divisor per job
	always_comb begin
		unique case (cmd.op)
			OP_AVG_WORK: begin
				div_num = NW'(aw_mul) + NW'(nw);
				div_den = DW'(wgt_p1);
			end
			OP_AVG_DEAD: begin
				div_num = NW'(ad_mul) + NW'(nd);
				div_den = DW'(wgt_p1);
			end
			OP_PMAX: begin
				div_num = NW'(aw_q) * NW'(FULL_SPEED);
				div_den = DW'(ad_q);
			end
			OP_UTIL: begin
				div_num = NW'(idle_q) * NW'(FULL_SPEED);
				div_den = DW'(t_c);
			end
			default: begin
				div_num = '0;
				div_den = '0;
			end
		endcase
	end

	assign div_start  = cmd.load && (cmd.op != OP_USED);
	assign c100_start = cmd.load && (cmd.op == OP_USED);

	dsg_div #(
		.NW (NW),
		.DW (DW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rem    (div_rem)
	);

	// divide by 100: remainder and next byte form a 15-bit partial dividend
	always_comb begin
		c100_v     = {c100_r_q, c100_x_q[UW-1 -: 8]};
		c100_prod  = {17'b0, c100_v} * {15'b0, RECIP_100};
		c100_digit = c100_prod[30:23];
		c100_back  = 15'(c100_digit) * 15'd100;
		c100_rem   = c100_v - c100_back;
	end

	// divide-by-100 step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c100_busy_q <= 1'b0;
			c100_done_q <= 1'b0;
			c100_cnt_q  <= '0;
		end else if (c100_start) begin
			c100_busy_q <= 1'b1;
			c100_done_q <= 1'b0;
			c100_cnt_q  <= CH_W'(NCH);
		end else if (c100_busy_q) begin
			c100_cnt_q <= c100_cnt_q - 1'b1;
			if (c100_cnt_q == CH_W'(1)) begin
				c100_busy_q <= 1'b0;
				c100_done_q <= 1'b1;
			end
		end else begin
			c100_done_q <= 1'b0;
		end
	end

	// quotient bytes shift in from the bottom as dividend bytes leave the top
	always_ff @(posedge clk) begin
		if (c100_start) begin
			c100_x_q <= UW'(t_q) * UW'(speed_q);
			c100_r_q <= '0;
		end else if (c100_busy_q) begin
			c100_x_q <= {c100_x_q[UW-9:0], c100_digit};
			c100_r_q <= c100_rem[6:0];
		end
	end

	// past-interval rule, then clamp to predicted max and to the floor
	always_comb begin
		s_sp = signed'({3'b0, speed_q});
		if (excess_q > CW'(idle_q))
			s_rule = signed'({3'b0, FULL_SPEED});
		else if (pct_q > hith_q)
			s_rule = s_sp + signed'({3'b0, up_q});
		else if (pct_q < loth_q)
			s_rule = s_sp - (signed'({3'b0, dnb_q}) - signed'({3'b0, pct_q}));
		else
			s_rule = s_sp;
		s_lim    = (s_rule > signed'({3'b0, maxl_q})) ? signed'({3'b0, maxl_q}) : s_rule;
		s_fin    = (s_lim < signed'({3'b0, minsp_q})) ? signed'({3'b0, minsp_q}) : s_lim;
		ns_close = s_fin[SPEED_W-1:0];
		ns_out   = cmd.close ? ns_close : speed_q;
	end

	// tick counters and interval state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= '0;
			run_q    <= '0;
			idle_q   <= '0;
			excess_q <= '0;
			aw_q     <= '0;
			ad_q     <= '0;
			maxl_q   <= FULL_SPEED;
		end else begin
			if (cmd.accept) begin
				tick_q <= tick_q + 1'b1;
				if (tick_is_idle)
					idle_q <= idle_q + 1'b1;
				else
					run_q <= run_q + 1'b1;
			end
			if (cmd.store) begin
				unique case (cmd.op)
					OP_AVG_WORK: aw_q <= div_quo[AVG_W-1:0];
					OP_AVG_DEAD: ad_q <= div_quo[AVG_W-1:0];
					OP_PMAX: begin
						if (ad_q == '0 || div_quo > NW'(FULL_SPEED))
							maxl_q <= FULL_SPEED;
						else
							maxl_q <= div_quo[SPEED_W-1:0];
					end
					default: ;
				endcase
			end
			if (cmd.emit && cmd.close) begin
				tick_q   <= '0;
				run_q    <= '0;
				idle_q   <= '0;
				excess_q <= xnew_q;
			end
		end
	end

	// per-interval scratch values
	always_ff @(posedge clk) begin
		if (cmd.accept)
			speed_q <= tick_current_speed;
		if (cmd.load && cmd.op == OP_UTIL) begin
			rt_q <= rt_c;
			t_q  <= t_c;
		end
		if (cmd.store) begin
			unique case (cmd.op)
				OP_UTIL: begin
					// utilization is 100 minus the rounded-up idle share
					if (t_q == '0)
						pct_q <= '0;
					else
						pct_q <= SPEED_W'(8'd100 - (div_quo[7:0] + {7'b0, (div_rem != '0)}));
				end
				OP_USED: begin
					if (c100_x_q >= UW'(rt_q))
						xnew_q <= '0;
					else
						xnew_q <= CW'(UW'(rt_q) - c100_x_q);
				end
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (cmd.emit)
			res_valid_q <= 1'b1;
		else if (result.ready)
			res_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_end_q  <= cmd.close;
			res_cr_q   <= (ns_out != speed_q);
			res_ns_q   <= ns_out;
			res_pmax_q <= maxl_q;
		end
	end

	assign result.valid          = res_valid_q;
	assign result.interval_end   = res_end_q;
	assign result.change_request = res_cr_q;
	assign result.new_speed      = res_ns_q;
	assign result.predicted_max  = res_pmax_q;

	assign status.close    = (tick_q >= intv_q);
	assign status.div_done = (cmd.op == OP_USED) ? c100_done_q : div_done;
	assign status.out_busy = res_valid_q && !result.ready;
endmodule
`default_nettype wire

FILE: rtl/dsg_ctrl.sv
// Controller: sequences tick accept, division jobs and result hand-off.
`default_nettype none
module dsg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick_valid,
	output logic                tick_ready,
	input  dsg_pkg::dp_status_t status,
	output dsg_pkg::dp_cmd_t    cmd
);
	import dsg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_LOAD,
		ST_WAIT,
		ST_EMIT
	} state_t;

	state_t state_q;
	op_t    op_q;
	logic   close_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= OP_AVG_WORK;
			close_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_valid)
						state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					close_q <= status.close;
					op_q    <= OP_AVG_WORK;
					state_q <= status.close ? ST_LOAD : ST_EMIT;
				end
				ST_LOAD: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (status.div_done) begin
						if (op_q == OP_USED) begin
							state_q <= ST_EMIT;
						end else begin
							op_q    <= op_t'(op_q + 3'd1);
							state_q <= ST_LOAD;
						end
					end
				end
				ST_EMIT: begin
					if (!status.out_busy)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// commands decoded from state
	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && tick_valid;
		cmd.load   = (state_q == ST_LOAD);
		cmd.store  = (state_q == ST_WAIT) && status.div_done;
		cmd.emit   = (state_q == ST_EMIT) && !status.out_busy;
		cmd.close  = close_q;
		cmd.op     = op_q;
	end

	assign tick_ready = (state_q == ST_IDLE);
endmodule
`default_nettype wire

FILE: rtl/dvs_speed_governor_core.sv
// Speed governor: per-tick counting, interval prediction and speed change requests.
//
// tick channel: one word per scheduler tick (is_idle, current_speed).
// result channel: one word per tick (interval_end, change_request,
//   new_speed, predicted_max).
// cfg port: cfg_we writes cfg_wdata into register cfg_index at the clock edge;
//   write only while no tick is in flight.
// A tick that does not close an interval goes from accept through the check
// and emit states to the result register. A closing tick runs four divisions
// on one shared bit-serial divider, then a divide by 100 at one dividend byte
// per cycle, before its result is emitted.
// One tick is worked on at a time; a new tick is taken only in the idle state.
// Reset (arst_n low) restores default settings, clears counters and
// averages, sets the predicted max to 100 and empties the result register.
// A stalled receiver holds the result word; the next tick is still taken and
// worked on, and its result waits until the register frees.
`default_nettype none
`include "dvs_speed_governor_core_macros.svh"
module dvs_speed_governor_core #(
	parameter int COUNTER_WIDTH = dsg_pkg::COUNTER_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	dsg_tick_if.sink                       tick,
	dsg_result_if.source                   result,
	input  logic                           cfg_we,
	input  logic [dsg_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dsg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import dsg_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       tick_ready;

	dsg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_valid (tick.valid),
		.tick_ready (tick_ready),
		.status     (status),
		.cmd        (cmd)
	);

	dsg_datapath #(
		.CW (COUNTER_WIDTH)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.tick_is_idle       (tick.is_idle),
		.tick_current_speed (tick.current_speed),
		.cfg_we             (cfg_we),
		.cfg_index          (cfg_index),
		.cfg_wdata          (cfg_wdata),
		.result             (result)
	);

	assign tick.ready = tick_ready;

	// checks
	`DSG_ASSERT_NEXT(a_one_tick, tick.valid && tick.ready, !tick.ready, "tick taken while busy")
	`DSG_ASSERT_SAME(a_quiet_no_change, result.valid && !result.interval_end, !result.change_request, "change request on quiet tick")
	`DSG_ASSERT_SAME(a_pmax_range, result.valid, result.predicted_max <= FULL_SPEED, "predicted max above full speed")
endmodule
`default_nettype wire
